@@ sv/jka_pkg.sv @@
// shared types and constants for the joystick key autorepeat block
`default_nettype none
package jka_pkg;

    localparam int NUM_KEYS   = 5;
    localparam int NUM_SLOTS  = 11;
    localparam int STAMP_W    = 32;

    typedef logic [2:0] key_t;
    typedef logic [1:0] kind_t;
    typedef logic [1:0] reg_idx_t;
    typedef logic [NUM_KEYS-1:0][STAMP_W-1:0] stamp_arr_t;

    localparam key_t KEY_UP    = 3'd0;
    localparam key_t KEY_DOWN  = 3'd1;
    localparam key_t KEY_LEFT  = 3'd2;
    localparam key_t KEY_RIGHT = 3'd3;
    localparam key_t KEY_FIRE  = 3'd4;

    localparam kind_t KIND_RELEASE = 2'd0;
    localparam kind_t KIND_DOWN    = 2'd1;
    localparam kind_t KIND_TYPED   = 2'd2;

    localparam reg_idx_t REG_THRESHOLD = 2'd0;
    localparam reg_idx_t REG_DELAY     = 2'd1;
    localparam reg_idx_t REG_INTERVAL  = 2'd2;
    localparam reg_idx_t REG_PRESENT   = 2'd3;

    localparam logic [6:0]  THRESHOLD_RESET = 7'd50;
    localparam logic [15:0] DELAY_RESET     = 16'd500;
    localparam logic [15:0] INTERVAL_RESET  = 16'd100;

    // event slot positions in the batch mask
    localparam int SLOT_H_DOWN  = 5;
    localparam int SLOT_H_TYPED = 6;
    localparam int SLOT_V_DOWN  = 7;
    localparam int SLOT_V_TYPED = 8;
    localparam int SLOT_F_DOWN  = 9;
    localparam int SLOT_F_TYPED = 10;

    typedef struct packed {
        logic [NUM_SLOTS-1:0] mask;
        key_t                 h_key;
        key_t                 v_key;
    } event_batch_t;

endpackage
`default_nettype wire

@@ sv/jka_decode.sv @@
// key detection, event batch and next key state for one poll
`default_nettype none
module jka_decode (
    input  wire logic [7:0]          stick_x,
    input  wire logic [7:0]          stick_y,
    input  wire logic                fire,
    input  wire logic [31:0]         now_ms,
    input  wire logic [6:0]          axis_threshold,
    input  wire logic [15:0]         initial_delay_ms,
    input  wire logic [15:0]         back_ms,
    input  wire logic [4:0]          held,
    input  wire jka_pkg::stamp_arr_t stamp,
    output jka_pkg::event_batch_t    batch,
    output logic [4:0]               held_next,
    output jka_pkg::stamp_arr_t      stamp_next
);
    import jka_pkg::*;

    logic signed [8:0] x_s;
    logic signed [8:0] y_s;
    logic signed [8:0] thr_s;
    logic signed [8:0] thr_neg;
    logic              right;
    logic              left;
    logic              up;
    logic              down;
    logic [4:0]        want;
    logic [4:0]        due;
    logic [4:0]        typ;
    logic [4:0]        fresh;
    logic [31:0]       now_back;
    key_t              hk;
    key_t              vk;

    always_comb
    begin
        x_s     = {stick_x[7], stick_x};
        y_s     = {stick_y[7], stick_y};
        thr_s   = {2'b00, axis_threshold};
        thr_neg = -thr_s;
        right   = x_s > thr_s;
        left    = !right && (x_s < thr_neg);
        up      = y_s > thr_s;
        down    = !up && (y_s < thr_neg);

        want = '0;
        want[KEY_UP]    = up;
        want[KEY_DOWN]  = down;
        want[KEY_LEFT]  = left;
        want[KEY_RIGHT] = right;
        want[KEY_FIRE]  = fire;

        now_back = now_ms - {16'd0, back_ms};
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            due[k] = (now_ms - stamp[k]) > {16'd0, initial_delay_ms};
        end
        fresh = want & ~held;
        typ   = want & (~held | due);

        hk = right ? KEY_RIGHT : KEY_LEFT;
        vk = up ? KEY_UP : KEY_DOWN;

        batch.h_key = hk;
        batch.v_key = vk;
        batch.mask  = '0;
        batch.mask[NUM_KEYS-1:0]  = ~want & held;
        batch.mask[SLOT_H_DOWN]   = fresh[hk];
        batch.mask[SLOT_H_TYPED]  = typ[hk];
        batch.mask[SLOT_V_DOWN]   = fresh[vk];
        batch.mask[SLOT_V_TYPED]  = typ[vk];
        batch.mask[SLOT_F_DOWN]   = fresh[KEY_FIRE];
        batch.mask[SLOT_F_TYPED]  = typ[KEY_FIRE];

        held_next = want;
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            if (fresh[k])
            begin
                stamp_next[k] = now_ms;
            end
            else if (want[k] && due[k])
            begin
                stamp_next[k] = now_back;
            end
            else
            begin
                stamp_next[k] = stamp[k];
            end
        end
    end

endmodule
`default_nettype wire

@@ sv/jka_serializer.sv @@
// pending event batch and output register, one event per cycle while the output is not stalled
`default_nettype none
module jka_serializer (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  batch_valid,
    input  wire jka_pkg::event_batch_t batch,
    output logic                       batch_ready,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output jka_pkg::key_t              out_key,
    output jka_pkg::kind_t             out_kind,
    output logic                       out_last
);
    import jka_pkg::*;

    logic [NUM_SLOTS-1:0] mask_reg;
    logic [NUM_SLOTS-1:0] mask_next;
    key_t                 h_key_reg;
    key_t                 v_key_reg;
    logic                 valid_reg;
    key_t                 key_reg;
    kind_t                kind_reg;
    logic                 last_reg;

    logic [NUM_SLOTS-1:0] lowest;
    logic [NUM_SLOTS-1:0] mask_after;
    logic [3:0]           idx;
    logic                 pop;
    key_t                 sel_key;
    kind_t                sel_kind;

    always_comb
    begin
        lowest     = mask_reg & (~mask_reg + 1'b1);
        mask_after = mask_reg & ~lowest;
        idx        = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (lowest[i])
            begin
                idx = idx | 4'(i);
            end
        end
        pop         = (mask_reg != '0) && (!valid_reg || out_ready);
        batch_ready = (mask_reg == '0) || (pop && (mask_after == '0));

        unique case (idx)
            4'd0:    begin sel_key = KEY_UP;    sel_kind = KIND_RELEASE; end
            4'd1:    begin sel_key = KEY_DOWN;  sel_kind = KIND_RELEASE; end
            4'd2:    begin sel_key = KEY_LEFT;  sel_kind = KIND_RELEASE; end
            4'd3:    begin sel_key = KEY_RIGHT; sel_kind = KIND_RELEASE; end
            4'd4:    begin sel_key = KEY_FIRE;  sel_kind = KIND_RELEASE; end
            4'd5:    begin sel_key = h_key_reg; sel_kind = KIND_DOWN;    end
            4'd6:    begin sel_key = h_key_reg; sel_kind = KIND_TYPED;   end
            4'd7:    begin sel_key = v_key_reg; sel_kind = KIND_DOWN;    end
            4'd8:    begin sel_key = v_key_reg; sel_kind = KIND_TYPED;   end
            4'd9:    begin sel_key = KEY_FIRE;  sel_kind = KIND_DOWN;    end
            4'd10:   begin sel_key = KEY_FIRE;  sel_kind = KIND_TYPED;   end
            default: begin sel_key = KEY_UP;    sel_kind = KIND_RELEASE; end
        endcase

        priority if (batch_valid && batch_ready)
        begin
            mask_next = batch.mask;
        end
        else if (pop)
        begin
            mask_next = mask_after;
        end
        else
        begin
            mask_next = mask_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg <= mask_next;
            if (pop)
            begin
                valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (batch_valid && batch_ready)
        begin
            h_key_reg <= batch.h_key;
            v_key_reg <= batch.v_key;
        end
        if (pop)
        begin
            key_reg  <= sel_key;
            kind_reg <= sel_kind;
            last_reg <= (mask_after == '0);
        end
    end

    assign out_valid = valid_reg;
    assign out_key   = key_reg;
    assign out_kind  = kind_reg;
    assign out_last  = last_reg;

endmodule
`default_nettype wire

@@ sv/joystick_key_autorepeat_core.sv @@
// top level of the joystick key autorepeat block
`default_nettype none
// One joystick poll is taken per request on the input stream and turned into
// zero to eight key events on the output stream: releases first in the order
// up, down, left, right, fire, then down and typed events for the detected
// keys. A poll is registered, decoded in one pass against the held flags and
// repeat stamps, and its events are handed to a serialiser that sends one
// event per cycle, unless the output stalls, through an output register, the
// last one flagged by tlast. A new poll is taken in the cycle its
// predecessor's last event is moved into the output register. Configuration
// registers sit on the APB port: threshold at 0x0, initial delay at 0x4,
// repeat interval at 0x8, present flag at 0xC.
module joystick_key_autorepeat_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // stick_x, stick_y, button_z, button_c, now_ms, zero pad
    input  wire logic [55:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // key_code, event_kind, zero pad
    output logic [7:0]       m_axis_tdata,
    output logic             m_axis_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import jka_pkg::*;

    logic [6:0]   threshold_reg;
    logic [15:0]  delay_reg;
    logic [15:0]  interval_reg;
    logic         present_reg;

    logic         in_valid_reg;
    logic [7:0]   x_reg;
    logic [7:0]   y_reg;
    logic         fire_reg;
    logic [31:0]  now_reg;

    logic [4:0]   held_reg;
    stamp_arr_t   stamp_reg;

    logic [4:0]   held_next;
    stamp_arr_t   stamp_next;
    event_batch_t batch;
    logic         batch_ready;
    logic [15:0]  back_ms;
    logic         consume;
    logic         cfg_write;
    reg_idx_t     cfg_idx;
    key_t         out_key;
    kind_t        out_kind;

    assign pready    = 1'b1;
    assign cfg_idx   = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;
    assign back_ms   = (delay_reg >= interval_reg) ? (delay_reg - interval_reg) : 16'd0;
    assign consume   = in_valid_reg && batch_ready;
    assign s_axis_tready = !in_valid_reg || batch_ready;

    always_comb
    begin
        unique case (cfg_idx)
            REG_THRESHOLD: prdata = {25'd0, threshold_reg};
            REG_DELAY:     prdata = {16'd0, delay_reg};
            REG_INTERVAL:  prdata = {16'd0, interval_reg};
            REG_PRESENT:   prdata = {31'd0, present_reg};
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
            delay_reg     <= DELAY_RESET;
            interval_reg  <= INTERVAL_RESET;
            present_reg   <= 1'b1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_THRESHOLD: threshold_reg <= pwdata[6:0];
                REG_DELAY:     delay_reg     <= pwdata[15:0];
                REG_INTERVAL:  interval_reg  <= pwdata[15:0];
                REG_PRESENT:   present_reg   <= pwdata[0];
                default:       threshold_reg <= threshold_reg;
            endcase
        end
    end

    // poll input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tvalid && s_axis_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (consume)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            x_reg    <= s_axis_tdata[7:0];
            y_reg    <= s_axis_tdata[15:8];
            fire_reg <= s_axis_tdata[16] | s_axis_tdata[17];
            now_reg  <= s_axis_tdata[49:18];
        end
    end

    // held flags and repeat stamps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg  <= '0;
            stamp_reg <= '0;
        end
        else if (consume && present_reg)
        begin
            held_reg  <= held_next;
            stamp_reg <= stamp_next;
        end
    end

    jka_decode u_decode (
        .stick_x          (x_reg),
        .stick_y          (y_reg),
        .fire             (fire_reg),
        .now_ms           (now_reg),
        .axis_threshold   (threshold_reg),
        .initial_delay_ms (delay_reg),
        .back_ms          (back_ms),
        .held             (held_reg),
        .stamp            (stamp_reg),
        .batch            (batch),
        .held_next        (held_next),
        .stamp_next       (stamp_next)
    );

    jka_serializer u_serializer (
        .clk         (clk),
        .rst_n       (rst_n),
        .batch_valid (in_valid_reg && present_reg),
        .batch       (batch),
        .batch_ready (batch_ready),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_key     (out_key),
        .out_kind    (out_kind),
        .out_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {3'd0, out_kind, out_key};

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_axis_tready)
        else $error("input register empty but request refused");

    a_vertical_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(held_reg[KEY_UP] && held_reg[KEY_DOWN]) &&
        !(held_reg[KEY_LEFT] && held_reg[KEY_RIGHT]))
        else $error("opposite directions held together");

    a_absent_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        !present_reg |=> $stable(held_reg) && $stable(stamp_reg))
        else $error("key state changed while controller absent");

endmodule
`default_nettype wire

@@ bench/testbench.sv @@
// self-checking bench for the joystick key autorepeat core
`timescale 1ns / 1ps

module testbench;

    import jka_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 12;

    typedef struct packed {
        key_t  key;
        kind_t kind;
        logic  last;
    } key_event_t;

    typedef struct packed {
        logic signed [7:0] x;
        logic signed [7:0] y;
        logic              z;
        logic              c;
        logic [31:0]       now;
        int                n_given;
        key_t              k0;
        kind_t             t0;
        key_t              k1;
        kind_t             t1;
    } poll_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // predictor state and register copies
    bit          held_keys [NUM_KEYS];
    logic [31:0] repeat_stamps [NUM_KEYS];
    logic [6:0]  thr_cfg;
    logic [15:0] delay_cfg;
    logic [15:0] interval_cfg;
    logic        present_cfg;

    key_event_t  derived_events [$];
    key_event_t  pending_key_events [$];

    int          mismatch_count = 0;
    int          quiet_cycles = 0;
    int          rx_stall = 0;
    int          rx_calm = 0;
    bit          idle_on = 1'b1;
    bit          tx_calm = 1'b0;
    logic [31:0] clock_ms = 32'd0;
    poll_row_t   pose;

    poll_row_t directed_polls [16] = '{
        '{8'sd0,    8'sd0,    1'b0, 1'b0, 32'd0,    0,  KEY_UP,    KIND_RELEASE,
          KEY_UP,    KIND_RELEASE},
        '{8'sd127,  8'sd0,    1'b0, 1'b0, 32'd10,   2,  KEY_RIGHT, KIND_DOWN,
          KEY_RIGHT, KIND_TYPED},
        '{8'sd127,  8'sd0,    1'b0, 1'b0, 32'd510,  0,  KEY_UP,    KIND_RELEASE,
          KEY_UP,    KIND_RELEASE},
        '{8'sd127,  8'sd0,    1'b0, 1'b0, 32'd511,  1,  KEY_RIGHT, KIND_TYPED,
          KEY_UP,    KIND_RELEASE},
        '{8'sd127,  8'sd0,    1'b0, 1'b0, 32'd612,  1,  KEY_RIGHT, KIND_TYPED,
          KEY_UP,    KIND_RELEASE},
        '{8'sd127,  8'sd0,    1'b0, 1'b0, 32'd712,  0,  KEY_UP,    KIND_RELEASE,
          KEY_UP,    KIND_RELEASE},
        '{8'sd127,  8'sd0,    1'b0, 1'b0, 32'd713,  1,  KEY_RIGHT, KIND_TYPED,
          KEY_UP,    KIND_RELEASE},
        '{8'sd0,    8'sd0,    1'b0, 1'b0, 32'd714,  1,  KEY_RIGHT, KIND_RELEASE,
          KEY_UP,    KIND_RELEASE},
        '{8'sd127,  8'sd127,  1'b0, 1'b0, 32'd1000, -1, KEY_UP,    KIND_RELEASE,
          KEY_UP,    KIND_RELEASE},
        '{8'sh80,   8'sh80,   1'b1, 1'b0, 32'd1001, -1, KEY_UP,    KIND_RELEASE,
          KEY_UP,    KIND_RELEASE},
        '{8'sd51,   8'sd127,  1'b0, 1'b1, 32'd1002, -1, KEY_UP,    KIND_RELEASE,
          KEY_UP,    KIND_RELEASE},
        '{8'sd50,   -8'sd50,  1'b0, 1'b0, 32'd1003, -1, KEY_UP,    KIND_RELEASE,
          KEY_UP,    KIND_RELEASE},
        '{-8'sd51,  8'sd51,   1'b1, 1'b1, 32'hFFFF_FF00, -1, KEY_UP, KIND_RELEASE,
          KEY_UP,    KIND_RELEASE},
        '{-8'sd51,  8'sd51,   1'b1, 1'b0, 32'h0000_0100, -1, KEY_UP, KIND_RELEASE,
          KEY_UP,    KIND_RELEASE},
        '{-8'sd50,  8'sd50,   1'b0, 1'b1, 32'h0000_0101, -1, KEY_UP, KIND_RELEASE,
          KEY_UP,    KIND_RELEASE},
        '{8'sd0,    8'sd0,    1'b0, 1'b0, 32'h0000_0102, 1,  KEY_FIRE, KIND_RELEASE,
          KEY_UP,    KIND_RELEASE}
    };

    joystick_key_autorepeat_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void add_event(input key_t k, input kind_t t);
        key_event_t ev;
        ev.key  = k;
        ev.kind = t;
        ev.last = 1'b0;
        derived_events = {derived_events, ev};
    endfunction

    // key events caused by one poll, with the held flags and stamps updated
    function automatic void derive_key_events(input logic signed [7:0] x,
                                              input logic signed [7:0] y,
                                              input logic z, input logic c,
                                              input logic [31:0] now);
        int          thr;
        key_t        det [3];
        int          ndet;
        bit          want [NUM_KEYS];
        logic [31:0] back;
        key_t        k;
        derived_events.delete();
        if (!present_cfg)
            return;
        thr  = int'(thr_cfg);
        ndet = 0;
        if (int'(x) > thr)
        begin
            det[ndet] = KEY_RIGHT;
            ndet++;
        end
        else if (int'(x) < -thr)
        begin
            det[ndet] = KEY_LEFT;
            ndet++;
        end
        if (int'(y) > thr)
        begin
            det[ndet] = KEY_UP;
            ndet++;
        end
        else if (int'(y) < -thr)
        begin
            det[ndet] = KEY_DOWN;
            ndet++;
        end
        if (z || c)
        begin
            det[ndet] = KEY_FIRE;
            ndet++;
        end
        for (int i = 0; i < NUM_KEYS; i++)
            want[i] = 1'b0;
        for (int i = 0; i < ndet; i++)
            want[det[i]] = 1'b1;
        for (int i = 0; i < NUM_KEYS; i++)
        begin
            if (!want[i] && held_keys[i])
            begin
                add_event(key_t'(i), KIND_RELEASE);
                held_keys[i] = 1'b0;
            end
        end
        back = (delay_cfg >= interval_cfg) ? {16'd0, delay_cfg - interval_cfg} : 32'd0;
        for (int i = 0; i < ndet; i++)
        begin
            k = det[i];
            if (!held_keys[k])
            begin
                add_event(k, KIND_DOWN);
                add_event(k, KIND_TYPED);
                held_keys[k]     = 1'b1;
                repeat_stamps[k] = now;
            end
            else if (32'(now - repeat_stamps[k]) > {16'd0, delay_cfg})
            begin
                add_event(k, KIND_TYPED);
                repeat_stamps[k] = now - back;
            end
        end
        if (derived_events.size() > 0)
            derived_events[derived_events.size() - 1].last = 1'b1;
    endfunction

    task automatic flag_mismatch(input string what);
        if (mismatch_count < 10)
            $display("mismatch: %s", what);
        mismatch_count++;
    endtask

    task automatic send_poll(input poll_row_t row);
        key_event_t ev;
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, row.now, row.c, row.z, row.y, row.x};
        do
            @(posedge clk);
        while (!s_axis_tready);
        derive_key_events(row.x, row.y, row.z, row.c, row.now);
        if (row.n_given < 0)
        begin
            foreach (derived_events[i])
                pending_key_events = {pending_key_events, derived_events[i]};
        end
        else
        begin
            for (int i = 0; i < row.n_given; i++)
            begin
                ev.key  = (i == 0) ? row.k0 : row.k1;
                ev.kind = (i == 0) ? row.t0 : row.t1;
                ev.last = (i == row.n_given - 1);
                pending_key_events = {pending_key_events, ev};
            end
        end
    endtask

    task automatic pause_polls(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
    endtask

    // sender holds off until every pending event is out, then lets the core go idle
    task automatic drain_events();
        pause_polls(1);
        while (pending_key_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input reg_idx_t idx, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_THRESHOLD: thr_cfg      = value[6:0];
            REG_DELAY:     delay_cfg    = value[15:0];
            REG_INTERVAL:  interval_cfg = value[15:0];
            REG_PRESENT:   present_cfg  = value[0];
            default: ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apb_read_check(input reg_idx_t idx, input logic [31:0] want);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== want)
            flag_mismatch($sformatf("register %0d read 0x%08h, expected 0x%08h",
                                    idx, prdata, want));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apply_config(input logic [6:0] thr, input logic [15:0] delay,
                                input logic [15:0] interval, input logic present);
        apb_write(REG_THRESHOLD, {25'd0, thr});
        apb_write(REG_DELAY, {16'd0, delay});
        apb_write(REG_INTERVAL, {16'd0, interval});
        apb_write(REG_PRESENT, {31'd0, present});
        apb_read_check(REG_THRESHOLD, {25'd0, thr_cfg});
        apb_read_check(REG_DELAY, {16'd0, delay_cfg});
        apb_read_check(REG_INTERVAL, {16'd0, interval_cfg});
        apb_read_check(REG_PRESENT, {31'd0, present_cfg});
    endtask

    function automatic logic signed [7:0] pick_axis();
        int t;
        int v;
        t = int'(thr_cfg);
        case ($urandom_range(0, 7))
            0: v = 127;
            1: v = -128;
            2: v = t + 1;
            3: v = -t - 1;
            4: v = t;
            5: v = -t;
            6: v = 0;
            default: v = int'($urandom_range(0, 255)) - 128;
        endcase
        if (v > 127)
            v = 127;
        if (v < -128)
            v = -128;
        return v[7:0];
    endfunction

    // mostly held poses so repeats build up, with occasional noise
    task automatic run_polls(input int count);
        int r;
        int d;
        for (int i = 0; i < count; i++)
        begin
            if (i % 10 == 0)
                tx_calm = ($urandom_range(0, 2) == 0);
            if (idle_on && !tx_calm && $urandom_range(0, 3) == 0)
                pause_polls($urandom_range(1, 5));
            r = $urandom_range(0, 9);
            case (r)
                5, 6: pose.x = pick_axis();
                7: pose.y = pick_axis();
                8: {pose.z, pose.c} = 2'($urandom_range(0, 3));
                9:
                begin
                    pose.x = 8'($urandom);
                    pose.y = 8'($urandom);
                    {pose.z, pose.c} = 2'($urandom_range(0, 3));
                end
                default: ;
            endcase
            d = int'(delay_cfg);
            case ($urandom_range(0, 9))
                7, 8: clock_ms += $urandom_range(d, d + int'(interval_cfg) + 2);
                9: clock_ms = $urandom;
                default: clock_ms += $urandom_range(0, d / 4 + 3);
            endcase
            pose.now     = clock_ms;
            pose.n_given = -1;
            send_poll(pose);
        end
    endtask

    always @(negedge clk)
    begin
        if (!idle_on)
            m_axis_tready <= 1'b1;
        else if (rx_stall > 0)
        begin
            m_axis_tready <= 1'b0;
            rx_stall <= rx_stall - 1;
        end
        else if (rx_calm > 0)
        begin
            m_axis_tready <= 1'b1;
            rx_calm <= rx_calm - 1;
        end
        else if ($urandom_range(0, 29) == 0)
        begin
            m_axis_tready <= 1'b1;
            rx_calm <= $urandom_range(20, 40);
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            m_axis_tready <= 1'b0;
            rx_stall <= $urandom_range(0, 4);
        end
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin : event_check
        key_event_t due_event;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_key_events.size() == 0)
                flag_mismatch($sformatf("unexpected event key %0d kind %0d last %0b",
                                        m_axis_tdata[2:0], m_axis_tdata[4:3],
                                        m_axis_tlast));
            else
            begin
                due_event = pending_key_events.pop_front();
                if (m_axis_tdata[2:0] !== due_event.key
                    || m_axis_tdata[4:3] !== due_event.kind
                    || m_axis_tlast !== due_event.last)
                    flag_mismatch($sformatf(
                        "event key %0d kind %0d last %0b, expected key %0d kind %0d last %0b",
                        m_axis_tdata[2:0], m_axis_tdata[4:3], m_axis_tlast,
                        due_event.key, due_event.kind, due_event.last));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (psel && penable && pready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("** joystick_key_autorepeat_core: FAILED **");
            $finish;
        end
    end

    initial
    begin
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        m_axis_tready <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        thr_cfg      = THRESHOLD_RESET;
        delay_cfg    = DELAY_RESET;
        interval_cfg = INTERVAL_RESET;
        present_cfg  = 1'b1;
        for (int i = 0; i < NUM_KEYS; i++)
        begin
            held_keys[i]     = 1'b0;
            repeat_stamps[i] = 32'd0;
        end
        pose = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset values, threshold edges, repeat timing and clock wrap
        foreach (directed_polls[i])
        begin
            if ($urandom_range(0, 3) == 0)
                pause_polls($urandom_range(1, 5));
            send_poll(directed_polls[i]);
        end
        clock_ms = 32'h0000_0200;
        drain_events();

        apply_config(7'($urandom_range(1, 126)), 16'd600, 16'd150, 1'b1);
        run_polls(35);
        drain_events();
        run_polls(35);
        drain_events();

        // zero threshold and zero delay: every held key repeats on any nonzero time step
        apply_config(7'd0, 16'd0, 16'd0, 1'b1);
        run_polls(25);
        drain_events();

        apply_config(7'd127, 16'd65535, 16'd65535, 1'b1);
        run_polls(25);
        drain_events();

        // interval above the delay saturates the step back
        apply_config(7'd30, 16'd20, 16'd65535, 1'b1);
        run_polls(30);
        drain_events();

        // polls are ignored while absent
        apply_config(7'd80, 16'd300, 16'd50, 1'b0);
        run_polls(15);
        drain_events();

        apply_config(7'($urandom_range(0, 127)), 16'($urandom_range(50, 1500)), 16'd40, 1'b1);
        interval_cfg = 16'($urandom_range(0, int'(delay_cfg)));
        apb_write(REG_INTERVAL, {16'd0, interval_cfg});
        run_polls(40);
        drain_events();

        idle_on = 1'b0;
        apply_config(7'($urandom_range(0, 127)), 16'($urandom_range(0, 400)), 16'd0, 1'b1);
        run_polls(30);
        drain_events();

        if (mismatch_count == 0)
            $display("** joystick_key_autorepeat_core: PASSED **");
        else
            $display("** joystick_key_autorepeat_core: FAILED **");
        $finish;
    end

endmodule
